[rtl/core/pmrs_pkg.sv]
// Package for the power monitor reading scaler.
// Holds the word types, reading-kind codes, sequencer states and scaling constants.
// No dependencies.
`default_nettype none

package pmrs_pkg;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [1:0] KIND_BUS_VOLTAGE   = 2'd0;
    localparam logic [1:0] KIND_SHUNT_VOLTAGE = 2'd1;
    localparam logic [1:0] KIND_CURRENT       = 2'd2;
    localparam logic [1:0] KIND_POWER         = 2'd3;

    localparam logic REG_CALIBRATION = 1'b0;
    localparam logic REG_SHUNT       = 1'b1;

    localparam logic [15:0] CAL_RESET          = 16'd4096;
    localparam logic [19:0] SHUNT_RESET        = 20'd100;
    localparam logic [15:0] CURRENT_SCALE_RESET = 16'd100;
    localparam logic [10:0] POWER_SCALE_RESET  = 11'd2;

    localparam int          DIV_STEPS      = 26;
    localparam logic [25:0] FULL_SCALE_NUM = 26'd40960000;
    localparam logic [15:0] SCALE_SAT      = 16'hFFFF;
    localparam logic [18:0] RECIP_50       = 19'd335545;
    localparam int          RECIP_SHIFT    = 24;

    localparam logic signed [16:0] BUS_LSB_MV   = 17'sd4;
    localparam logic signed [16:0] SHUNT_LSB_UV = 17'sd10;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] raw_word;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] scaled_value;
        logic               status;
    } t_out_word;

    typedef struct packed {
        logic [15:0] current_scale;
        logic [10:0] power_scale;
        logic        busy;
    } t_scale_info;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_MUL,
        SEQ_DIV,
        SEQ_SAT,
        SEQ_POWER
    } t_seq_state;

endpackage

`default_nettype wire

[rtl/core/pmrs_scale_ctrl.sv]
// Configuration registers and scale recompute sequencer.
// Divides the full-scale constant by calibration times shunt one bit per cycle.
// Depends on pmrs_pkg.
`default_nettype none

module pmrs_scale_ctrl (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [pmrs_pkg::PADDR_W-1:0] paddr,
    input  wire logic [pmrs_pkg::PDATA_W-1:0] pwdata,
    output logic      [pmrs_pkg::PDATA_W-1:0] prdata,
    output logic                             pready,
    output pmrs_pkg::t_scale_info            o_scales
);

    pmrs_pkg::t_seq_state r_state, n_state;
    logic [15:0] r_cal;
    logic [19:0] r_shunt;
    logic [15:0] r_current_scale, n_current_scale;
    logic [10:0] r_power_scale, n_power_scale;
    logic [35:0] r_denom, n_denom;
    logic [35:0] r_rem, n_rem;
    logic [25:0] r_quot, n_quot;
    logic [4:0]  r_cnt, n_cnt;

    logic        wr;
    logic [36:0] rem_shift;
    logic [36:0] rem_diff;
    logic [34:0] ps_prod;

    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == pmrs_pkg::REG_SHUNT) ? {12'd0, r_shunt} : {16'd0, r_cal};

    assign o_scales = {r_current_scale, r_power_scale, (r_state != pmrs_pkg::SEQ_IDLE)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= pmrs_pkg::SEQ_IDLE;
            r_cal           <= pmrs_pkg::CAL_RESET;
            r_shunt         <= pmrs_pkg::SHUNT_RESET;
            r_current_scale <= pmrs_pkg::CURRENT_SCALE_RESET;
            r_power_scale   <= pmrs_pkg::POWER_SCALE_RESET;
        end else begin
            r_state         <= n_state;
            r_current_scale <= n_current_scale;
            r_power_scale   <= n_power_scale;
            if (wr && paddr[2] == pmrs_pkg::REG_CALIBRATION) begin
                r_cal <= pwdata[15:0];
            end
            if (wr && paddr[2] == pmrs_pkg::REG_SHUNT) begin
                r_shunt <= pwdata[19:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_denom <= n_denom;
        r_rem   <= n_rem;
        r_quot  <= n_quot;
        r_cnt   <= n_cnt;
    end

    always_comb begin
        n_state         = r_state;
        n_current_scale = r_current_scale;
        n_power_scale   = r_power_scale;
        n_denom         = r_denom;
        n_rem           = r_rem;
        n_quot          = r_quot;
        n_cnt           = r_cnt;
        rem_shift       = {r_rem, r_quot[25]};
        rem_diff        = rem_shift - {1'b0, r_denom};
        ps_prod         = 35'(r_current_scale) * 35'(pmrs_pkg::RECIP_50);
        case (r_state)
            pmrs_pkg::SEQ_IDLE: begin
                if (wr) begin
                    n_state = pmrs_pkg::SEQ_MUL;
                end
            end
            pmrs_pkg::SEQ_MUL: begin
                n_denom = 36'(r_cal) * 36'(r_shunt);
                n_rem   = '0;
                n_quot  = pmrs_pkg::FULL_SCALE_NUM;
                n_cnt   = '0;
                n_state = pmrs_pkg::SEQ_DIV;
            end
            pmrs_pkg::SEQ_DIV: begin
                if (rem_shift >= {1'b0, r_denom}) begin
                    n_rem  = rem_diff[35:0];
                    n_quot = {r_quot[24:0], 1'b1};
                end else begin
                    n_rem  = rem_shift[35:0];
                    n_quot = {r_quot[24:0], 1'b0};
                end
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'(pmrs_pkg::DIV_STEPS - 1)) begin
                    n_state = pmrs_pkg::SEQ_SAT;
                end
            end
            pmrs_pkg::SEQ_SAT: begin
                if (r_denom == '0) begin
                    n_current_scale = '0;
                end else if (|r_quot[25:16]) begin
                    n_current_scale = pmrs_pkg::SCALE_SAT;
                end else begin
                    n_current_scale = r_quot[15:0];
                end
                n_state = pmrs_pkg::SEQ_POWER;
            end
            pmrs_pkg::SEQ_POWER: begin
                n_power_scale = ps_prod[pmrs_pkg::RECIP_SHIFT +: 11];
                n_state       = pmrs_pkg::SEQ_IDLE;
            end
            default: begin
                n_state = pmrs_pkg::SEQ_IDLE;
            end
        endcase
        // A write in the middle of a recompute starts it over with the new register values.
        if (wr) begin
            n_state = pmrs_pkg::SEQ_MUL;
        end
    end

    // The power scale is the current scale divided by fifty whenever no recompute runs.
    a_power_ratio: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pmrs_pkg::SEQ_IDLE) |->
            (17'(r_power_scale) * 17'd50 <= 17'(r_current_scale)) &&
            (17'(r_current_scale) < (17'(r_power_scale) + 17'd1) * 17'd50))
        else $error("power scale does not match current scale");

    a_zero_denom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pmrs_pkg::SEQ_SAT && r_denom == '0) |=> (r_current_scale == '0))
        else $error("zero divisor did not clear the current scale");

    a_write_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pmrs_pkg::SEQ_IDLE && wr) |=> (r_state == pmrs_pkg::SEQ_MUL))
        else $error("register write did not start a recompute");

endmodule

`default_nettype wire

[rtl/core/pmrs_scaler_pipe.sv]
// Reading datapath: input register, one shared multiplier, result register.
// Uses the held scales from the sequencer.
// Depends on pmrs_pkg.
`default_nettype none

module pmrs_scaler_pipe (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire pmrs_pkg::t_in_word    i_in_word,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output pmrs_pkg::t_out_word        o_out_word,
    input  wire pmrs_pkg::t_scale_info i_scales
);

    logic                r_s1_valid;
    pmrs_pkg::t_in_word  r_s1;
    logic                r_out_valid;
    pmrs_pkg::t_out_word r_out;

    logic                    out_load;
    logic                    s1_load;
    logic signed [16:0]      op_a;
    logic signed [16:0]      op_b;
    logic signed [33:0]      product;
    logic                    bad_scale;
    pmrs_pkg::t_out_word     n_out;

    assign out_load    = !r_out_valid || !i_out_stall;
    assign s1_load     = (!r_s1_valid || out_load) && !i_scales.busy;
    assign o_in_stall  = !s1_load;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    always_comb begin
        case (r_s1.kind)
            pmrs_pkg::KIND_BUS_VOLTAGE: begin
                op_a = signed'({4'd0, r_s1.raw_word[15:3]});
                op_b = pmrs_pkg::BUS_LSB_MV;
            end
            pmrs_pkg::KIND_SHUNT_VOLTAGE: begin
                op_a = signed'({r_s1.raw_word[15], r_s1.raw_word});
                op_b = pmrs_pkg::SHUNT_LSB_UV;
            end
            pmrs_pkg::KIND_CURRENT: begin
                op_a = signed'({r_s1.raw_word[15], r_s1.raw_word});
                op_b = signed'({1'b0, i_scales.current_scale});
            end
            pmrs_pkg::KIND_POWER: begin
                op_a = signed'({1'b0, r_s1.raw_word});
                op_b = signed'({6'd0, i_scales.power_scale});
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
        product   = op_a * op_b;
        bad_scale = (i_scales.current_scale == '0) || (i_scales.power_scale == '0);
        n_out.status       = bad_scale;
        n_out.scaled_value = bad_scale ? 32'sd0 : product[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= r_s1_valid;
            end
            if (s1_load) begin
                r_s1_valid <= i_in_valid;
            end else if (out_load) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_load && i_in_valid) begin
            r_s1 <= i_in_word;
        end
        if (out_load && r_s1_valid) begin
            r_out <= n_out;
        end
    end

    a_busy_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_scales.busy |-> o_in_stall)
        else $error("word accepted during scale recompute");

    a_status_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status) |-> (r_out.scaled_value == 32'sd0))
        else $error("invalid-scale result carries a nonzero value");

    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && out_load) |=> r_out_valid)
        else $error("input stage word was lost");

endmodule

`default_nettype wire

[rtl/core/power_monitor_reading_scaler_unit.sv]
// Throughput: one word per cycle unless the output stalls or a recompute runs.
// The single multiplier sits between the input register and the result register.
// A calibration or shunt write runs a recompute (multiply, 26 divide steps,
// saturate, power scale) during which input is stalled; a write during it restarts it.
// Reset loads calibration 4096, shunt 100 and their scales 100 and 2; no words pending.
`default_nettype none

module power_monitor_reading_scaler_unit (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire pmrs_pkg::t_in_word           i_in_word,
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output pmrs_pkg::t_out_word               o_out_word,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [pmrs_pkg::PADDR_W-1:0] paddr,
    input  wire logic [pmrs_pkg::PDATA_W-1:0] pwdata,
    output logic      [pmrs_pkg::PDATA_W-1:0] prdata,
    output logic                              pready
);

    pmrs_pkg::t_scale_info scales;

    pmrs_scale_ctrl u_scale_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_scales (scales)
    );

    pmrs_scaler_pipe u_scaler_pipe (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .i_scales    (scales)
    );

endmodule

`default_nettype wire

[tb/pmrs_reading_checker.sv]
// Checker for the power monitor reading scaler: watches the word channels and the APB port,
// predicts each scaled reading from its own copy of the scales and compares field by field.
// Depends on pmrs_pkg for the word types, reading kinds and register indexes.
module pmrs_reading_checker (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    input  wire logic                            i_in_stall,
    input  pmrs_pkg::t_in_word                   i_in_word,
    input  wire logic                            i_out_valid,
    input  wire logic                            i_out_stall,
    input  pmrs_pkg::t_out_word                  i_out_word,
    input  wire logic                            i_psel,
    input  wire logic                            i_penable,
    input  wire logic                            i_pwrite,
    input  wire logic [pmrs_pkg::PADDR_W-1:0]    i_paddr,
    input  wire logic [pmrs_pkg::PDATA_W-1:0]    i_pwdata,
    input  wire logic                            i_pready,
    output int                                   o_fail_count,
    output int                                   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint unsigned SCALE_NUMERATOR = 40960000;
    localparam longint unsigned SCALE_CEILING   = 65535;
    localparam int unsigned     POWER_NUM       = 20;
    localparam int unsigned     POWER_DEN       = 1000;
    localparam longint          MV_PER_BUS_LSB  = 4;
    localparam longint          UV_PER_SHUNT_LSB = 10;

    logic [15:0] cal_q;
    logic [19:0] shunt_q;
    logic [15:0] cur_scale;
    logic [10:0] pwr_scale;
    pmrs_pkg::t_out_word expected_readings [$];

    function automatic void refresh_scales();
        longint unsigned divisor;
        longint unsigned quotient;
        int unsigned     power;
        divisor = cal_q;
        divisor = divisor * shunt_q;
        if (divisor == 0) begin
            quotient = 0;
        end else begin
            quotient = SCALE_NUMERATOR / divisor;
            if (quotient > SCALE_CEILING) begin
                quotient = SCALE_CEILING;
            end
        end
        cur_scale = quotient[15:0];
        power = cur_scale;
        power = power * POWER_NUM / POWER_DEN;
        pwr_scale = power[10:0];
    endfunction

    function automatic pmrs_pkg::t_out_word scale_reading(pmrs_pkg::t_in_word w);
        pmrs_pkg::t_out_word r;
        longint raw_signed;
        longint v;
        raw_signed = $signed(w.raw_word);
        v = 0;
        r.status = 1'b0;
        if (cur_scale == 0 || pwr_scale == 0) begin
            r.status = 1'b1;
        end else begin
            case (w.kind)
                pmrs_pkg::KIND_BUS_VOLTAGE: begin
                    v = longint'(w.raw_word[15:3]) * MV_PER_BUS_LSB;
                end
                pmrs_pkg::KIND_SHUNT_VOLTAGE: begin
                    v = raw_signed * UV_PER_SHUNT_LSB;
                end
                pmrs_pkg::KIND_CURRENT: begin
                    v = raw_signed * longint'(cur_scale);
                end
                pmrs_pkg::KIND_POWER: begin
                    v = longint'(w.raw_word) * longint'(pwr_scale);
                end
                default: begin
                    v = 0;
                end
            endcase
        end
        r.scaled_value = v[31:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        pmrs_pkg::t_out_word want;
        if (!i_rst_n) begin
            cal_q = 16'd4096;
            shunt_q = 20'd100;
            refresh_scales();
            expected_readings.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_readings.size() == 0) begin
                    $display("%0t ns: result with none expected: scaled_value %0d status %0b",
                             $time, i_out_word.scaled_value, i_out_word.status);
                    o_fail_count++;
                end else begin
                    want = expected_readings.pop_front();
                    if (i_out_word.scaled_value !== want.scaled_value) begin
                        $display("%0t ns: scaled_value mismatch: expected %0d, got %0d",
                                 $time, want.scaled_value, i_out_word.scaled_value);
                        o_fail_count++;
                    end
                    if (i_out_word.status !== want.status) begin
                        $display("%0t ns: status mismatch: expected %0b, got %0b",
                                 $time, want.status, i_out_word.status);
                        o_fail_count++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                expected_readings.push_back(scale_reading(i_in_word));
            end
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr == {pmrs_pkg::REG_CALIBRATION, 2'b00}) begin
                    cal_q = i_pwdata[15:0];
                end else if (i_paddr == {pmrs_pkg::REG_SHUNT, 2'b00}) begin
                    shunt_q = i_pwdata[19:0];
                end
                refresh_scales();
            end
        end
        o_pending = expected_readings.size();
    end

endmodule

[tb/tb_power_monitor_reading_scaler_unit.sv]
// Top of the reading scaler testbench: clock, reset, word stimulus with random idling,
// APB calibration and shunt writes, watchdog and verdict.
// Depends on pmrs_pkg, the scaler unit and pmrs_reading_checker.
module tb_power_monitor_reading_scaler_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 5;
    localparam int SETTLE_CYCLES  = 6;
    localparam int WATCHDOG_LIMIT = 2000;

    logic                         i_clk       = 1'b0;
    logic                         i_rst_n     = 1'b0;
    logic                         i_in_valid  = 1'b0;
    pmrs_pkg::t_in_word           i_in_word   = '0;
    logic                         i_out_stall = 1'b0;
    logic                         psel        = 1'b0;
    logic                         penable     = 1'b0;
    logic                         pwrite      = 1'b0;
    logic [pmrs_pkg::PADDR_W-1:0] paddr       = '0;
    logic [pmrs_pkg::PDATA_W-1:0] pwdata      = '0;
    logic                         o_in_stall;
    logic                         o_out_valid;
    pmrs_pkg::t_out_word          o_out_word;
    logic [pmrs_pkg::PDATA_W-1:0] prdata;
    logic                         pready;

    int fail_count;
    int readings_pending;
    bit quiet         = 1'b0;
    int idle_pct      = 0;
    int stall_pct     = 0;
    int stall_left    = 0;
    int idle_cycles   = 0;
    int words_sent    = 0;
    int settings_used = 0;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    power_monitor_reading_scaler_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    pmrs_reading_checker reading_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_word    (i_in_word),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_word   (o_out_word),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_pready     (pready),
        .o_fail_count (fail_count),
        .o_pending    (readings_pending)
    );

    always @(negedge i_clk) begin
        if (quiet || !i_rst_n) begin
            stall_left = 0;
            i_out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if ($urandom_range(0, 99) < stall_pct) begin
            stall_left = $urandom_range(0, 12);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (psel && penable && pwrite && pready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: nothing moved for %0d cycles at %0t ns", idle_cycles, $time);
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic logic [15:0] corner_raw(int unsigned pick);
        case (pick)
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h8000;
            3: return 16'h7FFF;
            4: return 16'h0007;
            default: return 16'hFFF8;
        endcase
    endfunction

    function automatic pmrs_pkg::t_in_word random_word();
        pmrs_pkg::t_in_word w;
        w.kind = 2'($urandom_range(0, 3));
        if ($urandom_range(0, 7) == 0) begin
            w.raw_word = corner_raw($urandom_range(0, 5));
        end else begin
            w.raw_word = 16'($urandom_range(0, 16'hFFFF));
        end
        return w;
    endfunction

    task automatic send_word(input pmrs_pkg::t_in_word w);
        int gap;
        gap = 0;
        if (!quiet && $urandom_range(0, 99) < idle_pct) begin
            gap = $urandom_range(1, 13);
        end
        @(negedge i_clk);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word <= w;
        do @(posedge i_clk); while (o_in_stall);
        words_sent++;
    endtask

    task automatic play_random(input int count);
        repeat (count) send_word(random_word());
    endtask

    task automatic finish_pending();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (readings_pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [pmrs_pkg::PDATA_W-1:0] data);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic apply_setting(input logic [pmrs_pkg::PDATA_W-1:0] cal_word,
                                 input logic [pmrs_pkg::PDATA_W-1:0] shunt_word);
        finish_pending();
        write_reg(pmrs_pkg::REG_CALIBRATION, cal_word);
        write_reg(pmrs_pkg::REG_SHUNT, shunt_word);
        settings_used++;
    endtask

    initial begin
        pmrs_pkg::t_in_word w;
        int unsigned        cal_pick;
        int unsigned        shunt_pick;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        settings_used = 1;

        idle_pct = 20;
        stall_pct = 20;
        for (int k = 0; k < 4; k++) begin
            for (int c = 0; c < 6; c++) begin
                w.kind = 2'(k);
                w.raw_word = corner_raw(c);
                send_word(w);
            end
        end
        play_random(40);

        // Saturated current scale, with junk above each register's width.
        apply_setting(32'hABCD_0001, 32'hFFF0_0001);
        play_random(30);
        // Divisor far beyond the numerator.
        apply_setting(32'h0000_FFFF, 32'hFFFF_FFFF);
        play_random(30);
        apply_setting(32'd0, 32'd100);
        play_random(30);
        apply_setting(32'd100, 32'd0);
        play_random(30);
        // Smallest current scale that still gives a nonzero power scale.
        apply_setting(32'd4096, 32'd200);
        play_random(30);
        // Current scale valid but power scale truncated to zero.
        apply_setting(32'd4096, 32'd205);
        play_random(30);

        for (int s = 0; s < 5; s++) begin
            if ($urandom_range(0, 3) == 0) begin
                cal_pick = $urandom_range(0, 16'hFFFF);
                shunt_pick = $urandom_range(0, 20'hFFFFF);
            end else begin
                cal_pick = $urandom_range(1, 4096);
                shunt_pick = $urandom_range(1, 819200 / cal_pick);
            end
            idle_pct = (s % 2 == 0) ? 0 : $urandom_range(10, 50);
            stall_pct = (s % 2 == 1) ? 0 : $urandom_range(10, 40);
            apply_setting(cal_pick, shunt_pick);
            play_random(50);
        end

        quiet = 1'b1;
        cal_pick = $urandom_range(1, 2048);
        apply_setting(cal_pick, $urandom_range(1, 819200 / cal_pick));
        play_random(60);
        finish_pending();

        $display("Scaled %0d readings of all four kinds under %0d register settings,",
                 words_sent, settings_used);
        $display("including saturated, truncated and invalid scales and masked register writes.");
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

[power_monitor_reading_scaler_unit.f]
rtl/core/pmrs_pkg.sv
rtl/core/pmrs_scale_ctrl.sv
rtl/core/pmrs_scaler_pipe.sv
rtl/core/power_monitor_reading_scaler_unit.sv
tb/pmrs_reading_checker.sv
tb/tb_power_monitor_reading_scaler_unit.sv
